// ===== rtl/scf_pkg.sv =====
// Shared types and constants for the serial command framer.
`default_nettype none

package scf_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned REG_IDX_W = 2;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // result kinds
  localparam kind_t KIND_SINGLE = 2'd0;
  localparam kind_t KIND_LONG   = 2'd1;
  localparam kind_t KIND_EMPTY  = 2'd2;

  // register map
  localparam reg_idx_t REG_START_CHAR = 2'd0;
  localparam reg_idx_t REG_END_CHAR   = 2'd1;

  // register reset values: '_' and carriage return
  localparam byte_t START_CHAR_RST = 8'h5F;
  localparam byte_t END_CHAR_RST   = 8'h0D;

endpackage

`default_nettype wire

// ===== rtl/scf_if.sv =====
// Valid/ready channel interfaces of the serial command framer.
`default_nettype none

interface scf_rx_if import scf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scf_res_if import scf_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  byte_t data;
  logic  last;
  logic  truncated;

  modport source (output valid, output kind, output data, output last, output truncated,
                  input ready);
  modport sink   (input valid, input kind, input data, input last, input truncated,
                  output ready);
endinterface

interface scf_cfg_if import scf_pkg::*; ();
  logic     valid;
  logic     ready;
  reg_idx_t reg_index;
  byte_t    wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/serial_command_framer_core.sv =====
// Serial command framer top level: mode control, line store drain, result register.
//
// Splits a stream of received bytes into commands. In plain mode a byte equal
// to start_char (register 0, reset '_') enters long-command mode and gives no
// result; any other byte comes out as one single-byte command word (kind 0).
// In long mode bytes go into a DEPTH-entry line store until end_char (register
// 1, reset CR) arrives. The stored bytes then come out in order as kind-1
// words, last set on the final one, or as one kind-2 word with data zero if
// nothing was stored. Bytes beyond DEPTH are dropped and every word of that
// run carries truncated. rx.ready is high while the block is idle and the
// result register is empty or being emptied. A closing byte with stored bytes
// keeps the block busy while they drain: the line store has one read port
// with registered data, and each stored byte is read in ST_READ and then moved
// into the result register in ST_WAIT, which waits while the sink stalls.
// Configuration writes are always taken (cfg.ready is tied high) and must
// only happen while idle.
`default_nettype none

module serial_command_framer_core import scf_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  scf_rx_if.sink    rx,
  scf_res_if.source res,
  scf_cfg_if.sink   cfg
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,   // taking bytes
    ST_READ = 3'b010,   // line store read issued this cycle
    ST_WAIT = 3'b100    // read data ready, waiting for result register
  } state_t;

  state_t state, state_next;

  // configuration registers
  byte_t start_char;
  byte_t end_char;

  // framing state
  logic             long_mode, long_mode_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic             overflowed, overflowed_next;
  logic [IDX_W-1:0] rd_ptr, rd_ptr_next;

  // result register
  logic  res_valid, res_valid_next;
  kind_t res_kind, res_kind_next;
  byte_t res_data, res_data_next;
  logic  res_last, res_last_next;
  logic  res_trunc, res_trunc_next;

  // line store ports
  logic  ram_wr_en;
  logic  ram_rd_en;
  byte_t ram_rd_data;

  logic out_free;
  logic rx_fire;
  logic drain_last;

  assign out_free = !res_valid || res.ready;
  assign rx.ready = (state == ST_IDLE) && out_free;
  assign rx_fire  = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  assign drain_last = (CNT_W'(rd_ptr) + CNT_W'(1)) == fill_count;

  assign res.valid     = res_valid;
  assign res.kind      = res_kind;
  assign res.data      = res_data;
  assign res.last      = res_last;
  assign res.truncated = res_trunc;

  // store a long-command byte while room is left
  assign ram_wr_en = rx_fire && long_mode && (rx.rx_byte != end_char) &&
                     (fill_count < DEPTH_CNT);
  assign ram_rd_en = (state == ST_READ);

  scf_line_ram #(
    .DEPTH(DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (fill_count[IDX_W-1:0]),
    .wr_data (rx.rx_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_ptr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= START_CHAR_RST;
      end_char   <= END_CHAR_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.reg_index)
        REG_START_CHAR: start_char <= cfg.wr_data;
        REG_END_CHAR:   end_char   <= cfg.wr_data;
        default: ;      // unmapped index, ignored
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    long_mode_next  = long_mode;
    fill_count_next = fill_count;
    overflowed_next = overflowed;
    rd_ptr_next     = rd_ptr;
    res_valid_next  = res_valid && !res.ready;
    res_kind_next   = res_kind;
    res_data_next   = res_data;
    res_last_next   = res_last;
    res_trunc_next  = res_trunc;

    unique case (state)
      ST_IDLE: begin
        if (rx_fire) begin
          if (!long_mode) begin
            if (rx.rx_byte == start_char) begin
              long_mode_next  = 1'b1;
              fill_count_next = '0;
              overflowed_next = 1'b0;
            end else begin
              res_valid_next = 1'b1;
              res_kind_next  = KIND_SINGLE;
              res_data_next  = rx.rx_byte;
              res_last_next  = 1'b1;
              res_trunc_next = 1'b0;
            end
          end else if (rx.rx_byte != end_char) begin
            if (fill_count < DEPTH_CNT) begin
              fill_count_next = fill_count + CNT_W'(1);
            end else begin
              overflowed_next = 1'b1;
            end
          end else if (fill_count == '0) begin
            res_valid_next  = 1'b1;
            res_kind_next   = KIND_EMPTY;
            res_data_next   = '0;
            res_last_next   = 1'b1;
            res_trunc_next  = overflowed;
            long_mode_next  = 1'b0;
            overflowed_next = 1'b0;
          end else begin
            rd_ptr_next = '0;
            state_next  = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) begin
          res_valid_next = 1'b1;
          res_kind_next  = KIND_LONG;
          res_data_next  = ram_rd_data;
          res_last_next  = drain_last;
          res_trunc_next = overflowed;
          if (drain_last) begin
            long_mode_next  = 1'b0;
            fill_count_next = '0;
            overflowed_next = 1'b0;
            state_next      = ST_IDLE;
          end else begin
            rd_ptr_next = rd_ptr + IDX_W'(1);
            state_next  = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      long_mode  <= 1'b0;
      fill_count <= '0;
      overflowed <= 1'b0;
      rd_ptr     <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      long_mode  <= long_mode_next;
      fill_count <= fill_count_next;
      overflowed <= overflowed_next;
      rd_ptr     <= rd_ptr_next;
      res_valid  <= res_valid_next;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    res_kind  <= res_kind_next;
    res_data  <= res_data_next;
    res_last  <= res_last_next;
    res_trunc <= res_trunc_next;
  end

endmodule

`default_nettype wire

// ===== rtl/scf_line_ram.sv =====
// Line store: one write port, one read port, registered read data.
`default_nettype none

module scf_line_ram import scf_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire byte_t            wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output byte_t                 rd_data
);

  byte_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
